// ===== hdl/rsbk_pkg.sv =====
`timescale 1ns / 1ps

package rsbk_pkg;

   localparam int KEY_BITS          = 16;
   localparam int TAG_FIELD_BITS    = 16;
   localparam int MAX_RECORDS_DEF   = 16;
   localparam int TAG_BITS_DEF      = 16;

   // controller to output register
   typedef struct packed {
      logic load;
      logic last;
   } emit_type;

endpackage

// ===== hdl/rsbk_ram.sv =====
`timescale 1ns / 1ps

module rsbk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rsbk_ctrl.sv =====
`timescale 1ns / 1ps

module rsbk_ctrl #(
   parameter int MAX_RECORDS = rsbk_pkg::MAX_RECORDS_DEF,
   parameter int TAG_BITS    = rsbk_pkg::TAG_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [rsbk_pkg::KEY_BITS+TAG_BITS-1:0] in_word,
   input  logic                                 in_last,
   output logic                                 wr_en,
   output logic [$clog2(MAX_RECORDS)-1:0]       wr_addr,
   output logic [rsbk_pkg::KEY_BITS+TAG_BITS-1:0] wr_data,
   output logic [$clog2(MAX_RECORDS)-1:0]       rd_addr,
   input  logic [rsbk_pkg::KEY_BITS+TAG_BITS-1:0] rd_data,
   input  logic                                 out_free,
   output rsbk_pkg::emit_type                   emit
);

   import rsbk_pkg::*;

   localparam int ADDR_W = $clog2(MAX_RECORDS);
   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
   localparam int WORD_W = KEY_BITS + TAG_BITS;

   localparam logic [2:0] S_LOAD      = 3'd0;
   localparam logic [2:0] S_START     = 3'd1;
   localparam logic [2:0] S_PASS_LOAD = 3'd2;
   localparam logic [2:0] S_CMP       = 3'd3;
   localparam logic [2:0] S_END       = 3'd4;
   localparam logic [2:0] S_EMIT      = 3'd5;

   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_RECORDS);

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [ADDR_W-1:0] limit_ff, limit_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] last_idx_ff, last_idx_in;
   logic [WORD_W-1:0] carry_ff, carry_in;
   logic [CNT_W-1:0]  count_now;
   logic              accept;
   logic              swap;

   assign in_ready  = (state_ff == S_LOAD);
   assign accept    = in_valid && in_ready;
   assign count_now = (fill_ff != FULL) ? fill_ff + CNT_W'(1) : fill_ff;
   assign swap      = carry_ff[KEY_BITS-1:0] > rd_data[KEY_BITS-1:0];

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      limit_in    = limit_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      carry_in    = carry_ff;
      wr_en       = 1'b0;
      wr_addr     = pos_ff;
      wr_data     = carry_ff;
      rd_addr     = '0;
      emit        = '0;
      unique case (state_ff)
         S_LOAD: begin
            wr_addr = fill_ff[ADDR_W-1:0];
            wr_data = in_word;
            if (accept) begin
               wr_en   = (fill_ff != FULL);
               fill_in = count_now;
               if (in_last) begin
                  limit_in    = ADDR_W'(count_now - CNT_W'(1));
                  last_idx_in = ADDR_W'(count_now - CNT_W'(1));
                  state_in    = S_START;
               end
            end
         end
         S_START: begin
            rd_addr = '0;
            pos_in  = '0;
            idx_in  = '0;
            state_in = (limit_ff == '0) ? S_EMIT : S_PASS_LOAD;
         end
         S_PASS_LOAD: begin
            carry_in = rd_data;
            rd_addr  = pos_ff + ADDR_W'(1);
            state_in = S_CMP;
         end
         S_CMP: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (swap) begin
               wr_data = rd_data;
            end else begin
               wr_data  = carry_ff;
               carry_in = rd_data;
            end
            rd_addr = pos_ff + ADDR_W'(2);
            if (pos_ff + ADDR_W'(1) == limit_ff) begin
               state_in = S_END;
            end else begin
               pos_in = pos_ff + ADDR_W'(1);
            end
         end
         S_END: begin
            wr_en    = 1'b1;
            wr_addr  = limit_ff;
            wr_data  = carry_ff;
            rd_addr  = '0;
            pos_in   = '0;
            limit_in = limit_ff - ADDR_W'(1);
            state_in = (limit_ff == ADDR_W'(1)) ? S_EMIT : S_PASS_LOAD;
         end
         S_EMIT: begin
            rd_addr = idx_ff;
            if (out_free) begin
               emit.load = 1'b1;
               emit.last = (idx_ff == last_idx_ff);
               if (idx_ff == last_idx_ff) begin
                  fill_in  = '0;
                  state_in = S_LOAD;
               end else begin
                  idx_in  = idx_ff + ADDR_W'(1);
                  rd_addr = idx_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      limit_ff    <= limit_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      carry_ff    <= carry_in;
   end

endmodule

// ===== hdl/rsbk_out.sv =====
`timescale 1ns / 1ps

module rsbk_out #(
   parameter int TAG_BITS = rsbk_pkg::TAG_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rsbk_pkg::emit_type                     emit,
   input  logic [rsbk_pkg::KEY_BITS+TAG_BITS-1:0] word,
   output logic                                   out_free,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [31:0]                            rsp_tdata,
   output logic                                   rsp_tlast
);

   import rsbk_pkg::*;

   logic                          valid_ff, valid_in;
   logic [KEY_BITS-1:0]           key_ff;
   logic [TAG_FIELD_BITS-1:0]     tag_ff;
   logic                          last_ff;
   logic [TAG_BITS+TAG_FIELD_BITS-1:0] tag_ext;

   assign tag_ext  = {{TAG_FIELD_BITS{1'b0}}, word[KEY_BITS +: TAG_BITS]};
   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (emit.load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (emit.load) begin
         key_ff  <= word[KEY_BITS-1:0];
         tag_ff  <= tag_ext[TAG_FIELD_BITS-1:0];
         last_ff <= emit.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {tag_ff, key_ff};
   assign rsp_tlast  = last_ff;

endmodule

// ===== hdl/record_sort_by_key.sv =====
`timescale 1ns / 1ps

// Collects up to MAX_RECORDS records (16-bit key plus handle) into one RAM,
// then on the transfer marked tlast sorts them ascending by key, stable for
// equal keys, and streams the run out with tlast on its final record.
// Records beyond capacity are dropped. Loading accepts one record per cycle.
// The sort runs a single read-compare-write loop over the RAM; the sorted
// run then streams out one record per cycle when the output side does not
// stall. No input is taken during sort and output.
module record_sort_by_key #(
   parameter int MAX_RECORDS = rsbk_pkg::MAX_RECORDS_DEF,
   parameter int TAG_BITS    = rsbk_pkg::TAG_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // year_key[15:0], record_tag[31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sorted_key[15:0], sorted_tag[31:16]
   output logic        rsp_tlast
);

   import rsbk_pkg::*;

   localparam int ADDR_W = $clog2(MAX_RECORDS);
   localparam int WORD_W = KEY_BITS + TAG_BITS;

   logic [TAG_BITS+TAG_FIELD_BITS-1:0] tag_ext;
   logic [WORD_W-1:0] in_word;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              out_free;
   emit_type          emit;

   assign tag_ext = {{TAG_BITS{1'b0}}, req_tdata[31:16]};
   assign in_word = {tag_ext[TAG_BITS-1:0], req_tdata[15:0]};

   rsbk_ctrl #(
      .MAX_RECORDS(MAX_RECORDS),
      .TAG_BITS   (TAG_BITS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_word (in_word),
      .in_last (req_tlast),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .out_free(out_free),
      .emit    (emit)
   );

   rsbk_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_RECORDS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   rsbk_out #(
      .TAG_BITS(TAG_BITS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .word      (rd_data),
      .out_free  (out_free),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
